[rtl/fmt_pkg.sv]
// Shared types, constants and helpers for the integer to ASCII formatter.
`default_nettype none
package fmt_pkg;

  localparam int MAX_WIDTH   = 31;
  localparam int DIGIT_STORE = 20;
  localparam int ND_W        = $clog2(DIGIT_STORE + 1);
  localparam int IDX_W       = $clog2(DIGIT_STORE);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam logic [1:0] FILL_NONE  = 2'd0;
  localparam logic [1:0] FILL_SPACE = 2'd1;
  localparam logic [1:0] FILL_ZERO  = 2'd2;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        wide;
    logic        hex;
    logic        zero_fill;
    logic [4:0]  width;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_FILL,
    S_DIGIT
  } back_state_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else begin
      ch = CH_A + {4'b0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

[rtl/fmt_if.sv]
// Channel interfaces: formatting requests in, characters out.
`default_nettype none
interface fmt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        is_signed;
  logic        is_wide;
  logic        hex_base;
  logic [1:0]  fill_mode;
  logic [4:0]  field_width;

  modport source(output valid, value, is_signed, is_wide, hex_base, fill_mode, field_width,
                 input ready);
  modport sink(input valid, value, is_signed, is_wide, hex_base, fill_mode, field_width,
               output ready);
endinterface

interface fmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source(output valid, character, last_char, input ready);
  modport sink(input valid, character, last_char, output ready);
endinterface
`default_nettype wire

[rtl/fmt_front.sv]
// Front end: accepts a request and classifies it into magnitude, sign and fill.
`default_nettype none
module fmt_front (
  fmt_in_if.sink        item,
  output fmt_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  logic [63:0] masked;
  logic [63:0] negv;
  logic        negative;
  logic [4:0]  capped;

  always_comb begin
    masked   = item.is_wide ? item.value : {32'b0, item.value[31:0]};
    negative = item.is_signed & (item.is_wide ? item.value[63] : item.value[31]);
    negv     = 64'd0 - masked;
    capped   = (int'(item.field_width) > fmt_pkg::MAX_WIDTH) ?
               5'(fmt_pkg::MAX_WIDTH) : item.field_width;

    job.mag       = negative ? (item.is_wide ? negv : {32'b0, negv[31:0]}) : masked;
    job.neg       = negative;
    job.wide      = item.is_wide;
    job.hex       = item.hex_base;
    job.zero_fill = (item.fill_mode == fmt_pkg::FILL_ZERO);
    // Modes other than space or zero fill print no padding at all
    job.width     = (item.fill_mode == fmt_pkg::FILL_SPACE ||
                     item.fill_mode == fmt_pkg::FILL_ZERO) ? capped : 5'd0;
  end

  assign job_valid  = item.valid;
  assign item.ready = job_ready;

endmodule
`default_nettype wire

[rtl/fmt_queue.sv]
// Two-entry job queue between front and back.
`default_nettype none
module fmt_queue (
  input  logic          clk,
  input  logic          rst,
  input  fmt_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output fmt_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  fmt_pkg::job_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[rtl/fmt_back.sv]
// Back end: digit extraction by shift-subtract and character emission.
`default_nettype none
module fmt_back (
  input  logic          clk,
  input  logic          rst,
  input  fmt_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  fmt_out_if.source     text
);

  fmt_pkg::back_state_t     state, state_next;
  logic [63:0]              num, num_next;
  logic [3:0]               rem, rem_next;
  logic [2:0]               bcnt, bcnt_next;
  logic [fmt_pkg::ND_W-1:0] nd, nd_next;
  logic [4:0]               nfill, nfill_next;
  logic                     neg, wide, hex, zero_fill;
  logic [4:0]               width;
  logic [3:0]               digits [fmt_pkg::DIGIT_STORE];

  logic                     dig_we;
  logic [3:0]               dig_wd;
  logic                     load_job;
  logic                     out_load;
  logic [7:0]               out_char;
  logic                     out_last;
  logic                     can_load;

  // Eight restoring steps on one byte of the dividend
  logic [3:0]               r;
  logic [4:0]               t;
  logic [7:0]               qb;
  logic [63:0]              num_shift;
  logic [63:0]              dec_q;
  logic [63:0]              hex_q;
  logic                     byte_last;
  logic                     finish;
  logic [fmt_pkg::ND_W-1:0] nd_done;
  logic [fmt_pkg::ND_W-1:0] nd_m1;

  always_comb begin
    r = rem;
    for (int k = 7; k >= 0; k--) begin
      t = {r, num[56 + k]};
      if (t >= 5'd10) begin
        r     = 4'(t - 5'd10);
        qb[k] = 1'b1;
      end else begin
        r     = t[3:0];
        qb[k] = 1'b0;
      end
    end
    num_shift = {num[55:0], qb};
    dec_q     = wide ? num_shift : {32'b0, num_shift[31:0]};
    hex_q     = {4'b0, num[63:4]};
    byte_last = (bcnt == (wide ? 3'd7 : 3'd3));
  end

  assign can_load = !text.valid || text.ready;
  assign nd_m1    = nd - 1'b1;

  always_comb begin
    state_next = state;
    num_next   = num;
    rem_next   = rem;
    bcnt_next  = bcnt;
    nd_next    = nd;
    nfill_next = nfill;
    job_ready  = 1'b0;
    load_job   = 1'b0;
    dig_we     = 1'b0;
    dig_wd     = 4'd0;
    finish     = 1'b0;
    out_load   = 1'b0;
    out_char   = fmt_pkg::CH_ZERO;
    out_last   = 1'b0;
    nd_done    = nd;

    case (state)
      fmt_pkg::S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          load_job   = 1'b1;
          // Decimal 32-bit operands sit in the top half so only four bytes are walked
          num_next   = (job.wide || job.hex) ? job.mag : {job.mag[31:0], 32'b0};
          rem_next   = 4'd0;
          bcnt_next  = 3'd0;
          nd_next    = '0;
          state_next = fmt_pkg::S_DIV;
        end
      end
      fmt_pkg::S_DIV: begin
        if (hex) begin
          dig_we   = 1'b1;
          dig_wd   = num[3:0];
          num_next = hex_q;
          finish   = (hex_q == 64'd0);
        end else begin
          rem_next  = r;
          num_next  = num_shift;
          bcnt_next = bcnt + 3'd1;
          if (byte_last) begin
            dig_we    = 1'b1;
            dig_wd    = r;
            rem_next  = 4'd0;
            bcnt_next = 3'd0;
            num_next  = wide ? dec_q : {dec_q[31:0], 32'b0};
            finish    = (dec_q == 64'd0);
          end
        end
        if (dig_we && int'(nd) < fmt_pkg::DIGIT_STORE) begin
          nd_done = nd + 1'b1;
        end
        nd_next = nd_done;
        if (finish) begin
          nfill_next = (int'(width) > int'(nd_done)) ? 5'(int'(width) - int'(nd_done)) : 5'd0;
          if (neg) begin
            state_next = fmt_pkg::S_SIGN;
          end else if (int'(width) > int'(nd_done)) begin
            state_next = fmt_pkg::S_FILL;
          end else begin
            state_next = fmt_pkg::S_DIGIT;
          end
        end
      end
      fmt_pkg::S_SIGN: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_char   = fmt_pkg::CH_MINUS;
          state_next = (nfill != 5'd0) ? fmt_pkg::S_FILL : fmt_pkg::S_DIGIT;
        end
      end
      fmt_pkg::S_FILL: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_char   = zero_fill ? fmt_pkg::CH_ZERO : fmt_pkg::CH_SPACE;
          nfill_next = nfill - 5'd1;
          if (nfill == 5'd1) state_next = fmt_pkg::S_DIGIT;
        end
      end
      fmt_pkg::S_DIGIT: begin
        if (can_load) begin
          out_load = 1'b1;
          out_char = fmt_pkg::digit_ascii(digits[nd_m1[fmt_pkg::IDX_W-1:0]]);
          out_last = (nd == fmt_pkg::ND_W'(1));
          nd_next  = nd_m1;
          if (nd == fmt_pkg::ND_W'(1)) state_next = fmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fmt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nd    <= '0;
      nfill <= 5'd0;
      bcnt  <= 3'd0;
    end else begin
      nd    <= nd_next;
      nfill <= nfill_next;
      bcnt  <= bcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    num <= num_next;
    rem <= rem_next;
    if (load_job) begin
      neg       <= job.neg;
      wide      <= job.wide;
      hex       <= job.hex;
      zero_fill <= job.zero_fill;
      width     <= job.width;
    end
    if (dig_we && int'(nd) < fmt_pkg::DIGIT_STORE) begin
      digits[nd[fmt_pkg::IDX_W-1:0]] <= dig_wd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (out_load) begin
      text.valid <= 1'b1;
    end else if (text.ready) begin
      text.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      text.character <= out_char;
      text.last_char <= out_last;
    end
  end

`ifndef SYNTHESIS
  a_digit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == fmt_pkg::S_DIGIT) |-> (nd != '0))
    else $error("digit emission with empty digit store");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == fmt_pkg::S_FILL) |-> (nfill != 5'd0))
    else $error("fill emission with zero fill count");

  a_narrow_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == fmt_pkg::S_DIV && !hex && !wide) |-> (bcnt <= 3'd3))
    else $error("32-bit division walked past four bytes");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == fmt_pkg::S_IDLE))
    else $error("last character not followed by idle");
`endif

endmodule
`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// Top level: integer to ASCII formatter, front classifier, job queue and digit back end.
// The back end picks up a job while idle, then divides out the digits one at a time with
//   the byte-serial shift-subtract divider: eight bytes per digit (64-bit decimal), four bytes
//   (32-bit decimal) or one nibble shift (hex); then one character per cycle while the receiver
//   is ready. It takes no new job until the last character of the current one is loaded.
// A two-entry queue lets the front accept up to two more items while one is being worked.
// Reset (rst, synchronous) empties the queue, idles the back end and drops the output beat.
`default_nettype none
module integer_to_ascii_formatter (
  input  logic       clk,
  input  logic       rst,
  fmt_in_if.sink     item,
  fmt_out_if.source  text
);

  // Front to queue
  fmt_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;

  // Queue to back end
  fmt_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;

  // Classifies sign, masks narrow operands, resolves the fill request
  fmt_front u_front (
    .item      (item),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Decouples accepting requests from the slow digit loop
  fmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Divides out digits, then streams sign, fill and digits, one beat each
  fmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .text      (text)
  );

endmodule
`default_nettype wire

[test/integer_to_ascii_formatter_test.sv]
// Self-checking testbench for the integer to ASCII formatter, directed table then random traffic.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_test;

  // fill_mode 3 has no package name; the block treats it as no padding
  localparam logic [1:0] FILL_UNDEF = 2'd3;
  localparam int QUIET_LIMIT = 5000;  // cycles without any beat before the run is called hung
  localparam int LONG_HOLD = 400;     // receiver hold-off, long enough to fill the job queue
  localparam int RANDOM_ITEMS = 380;
  localparam int TAIL_CYCLES = 300;   // settle time after the last expected character

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic        is_wide;
    logic        hex_base;
    logic [1:0]  fill_mode;
    logic [4:0]  field_width;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } char_beat_t;

  // A directed row: the request, plus its text when it is obvious; empty text means predict it.
  typedef struct {
    fmt_req_t req;
    string    text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fmt_in_if  item ();
  fmt_out_if text ();

  integer_to_ascii_formatter dut (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .text (text)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  char_beat_t expected_chars [$];  // characters still owed by the block, oldest first
  string      typed_text [$];      // per offered item: typed text, or empty to predict
  stim_row_t  directed_rows [$];
  int         mismatches = 0;
  int         failures = 0;
  bit         hold_request = 1'b0;  // main asks the receiver for one long hold-off

  // Formatter model: sign, fill after the sign, then digits most significant first.
  task automatic predict_text(input fmt_req_t r);
    logic [63:0] mag;
    logic [3:0]  digit;
    logic [7:0]  digit_buf [0:19];
    logic [7:0]  fill_ch;
    int          pad;
    int          nd;
    char_beat_t  line [$];
    mag = r.is_wide ? r.value : {32'd0, r.value[31:0]};
    nd = 0;
    if (r.is_signed && (r.is_wide ? mag[63] : mag[31])) begin
      mag = -mag;
      if (!r.is_wide) begin
        mag[63:32] = 32'd0;
      end
      line.push_back('{fmt_pkg::CH_MINUS, 1'b0});
    end
    // fill modes other than space and zero ignore the width
    pad = (r.fill_mode == fmt_pkg::FILL_SPACE || r.fill_mode == fmt_pkg::FILL_ZERO) ?
          int'(r.field_width) : 0;
    fill_ch = (r.fill_mode == fmt_pkg::FILL_ZERO) ? fmt_pkg::CH_ZERO : fmt_pkg::CH_SPACE;
    do begin
      if (r.hex_base) begin
        digit = mag[3:0];
        mag = mag >> 4;
      end else begin
        digit = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      digit_buf[nd] = (digit < 4'd10) ? fmt_pkg::CH_ZERO + 8'(digit) :
                      fmt_pkg::CH_A + 8'(digit) - 8'd10;
      nd++;
    end while (mag != 64'd0);
    // the width never cuts digits
    for (int i = nd; i < pad; i++) begin
      line.push_back('{fill_ch, 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      line.push_back('{digit_buf[i], 1'b0});
    end
    line[line.size() - 1].last_char = 1'b1;
    foreach (line[i]) begin
      expected_chars.push_back(line[i]);
    end
  endtask

  task automatic expect_typed(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_chars.push_back('{s[i], i == s.len() - 1});
    end
  endtask

  function automatic void add_row(input logic [63:0] value, input logic sgn, input logic wide,
                                  input logic hex, input logic [1:0] mode,
                                  input logic [4:0] width, input string s);
    stim_row_t row;
    row.req = '{value, sgn, wide, hex, mode, width};
    row.text = s;
    directed_rows.push_back(row);
  endfunction

  // Random request: mostly plain random operands, with a good share of small values,
  // negatives, powers of the base and boundary values so every digit path gets hit.
  function automatic fmt_req_t random_request();
    fmt_req_t    r;
    logic [63:0] p;
    r.value = {$urandom, $urandom};
    r.is_signed = 1'($urandom_range(0, 1));
    r.is_wide = 1'($urandom_range(0, 1));
    r.hex_base = 1'($urandom_range(0, 1));
    r.fill_mode = 2'($urandom_range(0, 3));
    r.field_width = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0: r.value = {r.value[63:32], 32'($urandom_range(0, 99))};
      1: r.value = -64'($urandom_range(0, 999));
      2: begin
        case ($urandom_range(0, 6))
          0: r.value = 64'd0;
          1: r.value = 64'h0000_0000_7FFF_FFFF;
          2: r.value = 64'h0000_0000_8000_0000;
          3: r.value = 64'h0000_0000_FFFF_FFFF;
          4: r.value = 64'h8000_0000_0000_0000;
          5: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
          default: r.value = '1;
        endcase
      end
      3: begin
        // powers of ten or sixteen, minus zero or one, to ripple every digit
        p = 64'd1;
        if (r.hex_base) begin
          p = p << (4 * $urandom_range(0, 15));
        end else begin
          repeat ($urandom_range(0, 19)) p = p * 64'd10;
        end
        r.value = p - 64'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, starting at a falling edge; returns at the falling edge after acceptance.
  // valid stays high across back-to-back beats so it never sees two writes in one step.
  task automatic send_item(input fmt_req_t r, input string s, input int gap);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_text.push_back(s);
    item.valid <= 1'b1;
    item.value <= r.value;
    item.is_signed <= r.is_signed;
    item.is_wide <= r.is_wide;
    item.hex_base <= r.hex_base;
    item.fill_mode <= r.fill_mode;
    item.field_width <= r.field_width;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Expectations are queued at the accepting edge of the input beat.
  always @(posedge clk) begin : accept_item
    string s;
    if (!rst && item.valid && item.ready) begin
      s = typed_text.pop_front();
      if (s.len() != 0) begin
        expect_typed(s);
      end else begin
        predict_text('{item.value, item.is_signed, item.is_wide, item.hex_base,
                       item.fill_mode, item.field_width});
      end
    end
  end

  // Every character beat is checked against the oldest expectation.
  always @(posedge clk) begin : check_char
    char_beat_t want;
    if (!rst && text.valid && text.ready) begin
      if (expected_chars.size() == 0) begin
        failures++;
        if (mismatches < 10) begin
          $display("unexpected char beat: char %h last %b", text.character, text.last_char);
        end
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (text.character !== want.character || text.last_char !== want.last_char) begin
          failures++;
          if (mismatches < 10) begin
            $display("char mismatch: expected %h last %b, got %h last %b",
                     want.character, want.last_char, text.character, text.last_char);
          end
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall per beat, quiet phases with none, and one long hold-off on request.
  initial begin : receiver
    int  stall;
    int  beats;
    bit  rx_quiet;
    text.ready = 1'b0;
    beats = 0;
    rx_quiet = 1'b0;
    @(negedge clk);
    forever begin
      if (beats % 48 == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        text.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      text.ready <= 1'b1;
      @(posedge clk);
      while (!text.valid) @(posedge clk);
      @(negedge clk);
      beats++;
    end
  end

  // Watchdog: any beat on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item.valid && item.ready) || (text.valid && text.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("integer_to_ascii_formatter verification failed");
    $finish;
  end

  initial begin : stimulus
    bit tx_quiet;
    int gap;
    item.valid = 1'b0;
    item.value = '0;
    item.is_signed = 1'b0;
    item.is_wide = 1'b0;
    item.hex_base = 1'b0;
    item.fill_mode = fmt_pkg::FILL_NONE;
    item.field_width = '0;
    tx_quiet = 1'b0;

    //       value                  sgn   wide  hex   fill        width text
    add_row(64'd0,                 1'b0, 1'b0, 1'b0, fmt_pkg::FILL_NONE,  5'd0,  "0");
    add_row(64'd0,                 1'b1, 1'b1, 1'b1, fmt_pkg::FILL_NONE,  5'd0,  "0");
    add_row(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b0, fmt_pkg::FILL_NONE, 5'd0, "4294967295");
    add_row(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0, fmt_pkg::FILL_NONE, 5'd0, "-1");
    // most negative values: magnitude is the unsigned negation
    add_row(64'h0000_0000_8000_0000, 1'b1, 1'b0, 1'b0, fmt_pkg::FILL_NONE, 5'd0, "-2147483648");
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b0, fmt_pkg::FILL_NONE, 5'd0,
            "-9223372036854775808");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, fmt_pkg::FILL_NONE, 5'd0,
            "18446744073709551615");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, fmt_pkg::FILL_NONE, 5'd0,
            "FFFFFFFFFFFFFFFF");
    // narrow operand: upper half is ignored
    add_row(64'hFFFF_FFFF_1234_5678, 1'b0, 1'b0, 1'b1, fmt_pkg::FILL_NONE, 5'd0, "12345678");
    add_row(64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0, 1'b0, fmt_pkg::FILL_NONE, 5'd0, "2147483647");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, fmt_pkg::FILL_NONE, 5'd0,
            "7FFFFFFFFFFFFFFF");
    add_row(64'd42,                1'b0, 1'b0, 1'b0, fmt_pkg::FILL_SPACE, 5'd5,  "   42");
    // fill goes after the sign
    add_row(64'hFFFF_FFFF_FFFF_FFD6, 1'b1, 1'b0, 1'b0, fmt_pkg::FILL_ZERO, 5'd5, "-00042");
    add_row(64'hFFFF_FFFF_FFFF_FFD6, 1'b1, 1'b1, 1'b0, fmt_pkg::FILL_SPACE, 5'd5, "-   42");
    add_row(64'd42,                1'b0, 1'b0, 1'b0, fmt_pkg::FILL_NONE,  5'd10, "42");
    add_row(64'd42,                1'b0, 1'b0, 1'b0, FILL_UNDEF,          5'd10, "42");
    // width shorter than the digits never truncates
    add_row(64'd12345,             1'b0, 1'b0, 1'b0, fmt_pkg::FILL_ZERO,  5'd3,  "12345");
    add_row(64'h0000_0000_DEAD_BEEF, 1'b0, 1'b0, 1'b1, fmt_pkg::FILL_SPACE, 5'd0, "DEADBEEF");
    add_row(64'd15,                1'b0, 1'b0, 1'b1, fmt_pkg::FILL_NONE,  5'd0,  "F");
    add_row(64'd16,                1'b0, 1'b0, 1'b1, fmt_pkg::FILL_NONE,  5'd0,  "10");
    add_row(64'd10,                1'b0, 1'b1, 1'b0, fmt_pkg::FILL_NONE,  5'd0,  "10");
    add_row(64'd0,                 1'b0, 1'b0, 1'b0, fmt_pkg::FILL_ZERO,  5'd31, "");
    add_row(64'h0000_0000_00AB_CDEF, 1'b0, 1'b1, 1'b1, fmt_pkg::FILL_ZERO, 5'd31, "");
    // longest text: sign plus 31 places
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b0, fmt_pkg::FILL_ZERO, 5'd31, "");
    add_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, fmt_pkg::FILL_SPACE, 5'd25, "");

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].text, $urandom_range(0, 13));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
      end
      // hold the output back while input keeps coming, so the queue fills and input stalls
      if (n == 120) begin
        hold_request = 1'b1;
      end
      // sender pause: drop valid and let everything drain before continuing
      if (n == 250) begin
        item.valid <= 1'b0;
        @(negedge clk);
        while (expected_chars.size() != 0 || typed_text.size() != 0) @(negedge clk);
      end
      gap = tx_quiet ? 0 : $urandom_range(0, 13);
      send_item(random_request(), "", gap);
    end
    item.valid <= 1'b0;

    while (expected_chars.size() != 0 || typed_text.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("integer_to_ascii_formatter verification clean");
    end else begin
      $display("integer_to_ascii_formatter verification failed");
    end
    $finish;
  end

endmodule
